// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file for its concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== hw/rtl/bfcc_pkg.sv =====
// Types and constants shared by the frame checker and classifier modules.
package bfcc_pkg;

    localparam int MAX_FRAME_BYTES = 255;
    localparam int COUNT_W         = 8;
    localparam int HEAD_DEPTH      = 6;
    localparam int MIN_FRAME_BYTES = 5;
    localparam int QUEUE_DEPTH     = 2;
    localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] DEFAULT_PARTNER = 8'h68;
    localparam logic [7:0] DEFAULT_OWN     = 8'h18;
    localparam logic [7:0] POLL_LENGTH     = 8'd3;
    localparam logic [7:0] POLL_CODE       = 8'h01;
    localparam logic [7:0] CMD_LENGTH      = 8'd5;
    localparam logic [7:0] CMD_MARK        = 8'h38;

    localparam logic [7:0] CFG_PARTNER_ADDR = 8'd0;
    localparam logic [7:0] CFG_OWN_ADDR     = 8'd1;

    typedef enum logic [2:0] {
        VERDICT_SHORT   = 3'd0,
        VERDICT_RXERR   = 3'd1,
        VERDICT_BADXOR  = 3'd2,
        VERDICT_ZEROLEN = 3'd3,
        VERDICT_OTHER   = 3'd4,
        VERDICT_POLL    = 3'd5,
        VERDICT_RADIO   = 3'd6,
        VERDICT_UNKNOWN = 3'd7
    } verdict_t;

    typedef logic [HEAD_DEPTH-1:0][7:0] head_t;

    // What the front end knows about a finished frame.
    typedef struct packed {
        logic  too_short;
        logic  rx_error;
        logic  bad_xor;
        head_t head;
    } frame_rec_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic [7:0] partner_addr;
        logic [7:0] own_addr;
    } cfg_t;

endpackage

// ===== hw/rtl/bfcc_front.sv =====
// Front end: accumulates count, XOR, error flag and head bytes of a frame.
module bfcc_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_rx_byte,
    input  logic                s_rx_ok,
    input  logic                s_frame_end,
    input  bfcc_pkg::q_status_t q_stat,
    output logic                push,
    output bfcc_pkg::frame_rec_t rec
);
    import bfcc_pkg::*;

    logic [COUNT_W-1:0] count_reg, count_next, count_upd;
    logic [7:0]         xor_reg, xor_next, xor_upd;
    logic               err_reg, err_next, err_upd;
    head_t              head_reg, head_next, head_upd;
    logic               accept;

    assign s_ready = !q_stat.full;
    assign accept  = s_valid && s_ready;
    assign push    = accept && s_frame_end;

    always_comb begin
        count_upd = (count_reg < COUNT_W'(MAX_FRAME_BYTES)) ? count_reg + 1'b1 : count_reg;
        xor_upd   = xor_reg ^ s_rx_byte;
        err_upd   = err_reg | !s_rx_ok;
        for (int i = 0; i < HEAD_DEPTH; i++) begin
            head_upd[i] = (count_reg == COUNT_W'(i)) ? s_rx_byte : head_reg[i];
        end

        rec.too_short = count_upd < COUNT_W'(MIN_FRAME_BYTES);
        rec.rx_error  = err_upd;
        rec.bad_xor   = xor_upd != 8'h00;
        rec.head      = head_upd;

        count_next = count_reg;
        xor_next   = xor_reg;
        err_next   = err_reg;
        head_next  = head_reg;
        if (accept) begin
            if (s_frame_end) begin
                // Frame is done: start the next one from a clean state.
                count_next = '0;
                xor_next   = '0;
                err_next   = 1'b0;
                head_next  = '0;
            end else begin
                count_next = count_upd;
                xor_next   = xor_upd;
                err_next   = err_upd;
                head_next  = head_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            xor_reg   <= '0;
            err_reg   <= 1'b0;
            head_reg  <= '0;
        end else begin
            count_reg <= count_next;
            xor_reg   <= xor_next;
            err_reg   <= err_next;
            head_reg  <= head_next;
        end
    end

endmodule

// ===== hw/rtl/bfcc_queue.sv =====
// Two-entry queue of finished frame records between front and back.
module bfcc_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  bfcc_pkg::frame_rec_t push_rec,
    input  logic                 pop,
    output bfcc_pkg::frame_rec_t head_rec,
    output bfcc_pkg::q_status_t  stat
);
    import bfcc_pkg::*;

    frame_rec_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;
    logic                do_push, do_pop;

    assign stat.full  = cnt_reg == QCNT_W'(QUEUE_DEPTH);
    assign stat.empty = cnt_reg == '0;
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head_rec   = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

// ===== hw/rtl/bfcc_back.sv =====
// Back end: classifies a queued frame record and holds the result register.
module bfcc_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  bfcc_pkg::cfg_t       cfg,
    input  bfcc_pkg::frame_rec_t rec,
    input  bfcc_pkg::q_status_t  q_stat,
    output logic                 pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [2:0]           m_verdict,
    output logic [7:0]           m_frame_source,
    output logic [7:0]           m_frame_dest,
    output logic [7:0]           m_frame_length,
    output logic [7:0]           m_command_code,
    output logic [7:0]           m_command_param
);
    import bfcc_pkg::*;

    logic       valid_reg, valid_next;
    verdict_t   verdict_reg, verdict_c;
    logic [7:0] src_reg, dst_reg, len_reg, code_reg, param_reg;
    logic [7:0] code_c, param_c;

    assign pop = !q_stat.empty && (!valid_reg || m_ready);

    always_comb begin
        code_c  = '0;
        param_c = '0;
        if (rec.too_short) begin
            verdict_c = VERDICT_SHORT;
        end else if (rec.rx_error) begin
            verdict_c = VERDICT_RXERR;
        end else if (rec.bad_xor) begin
            verdict_c = VERDICT_BADXOR;
        end else if (rec.head[1] == 8'h00) begin
            verdict_c = VERDICT_ZEROLEN;
        end else if (rec.head[0] != cfg.partner_addr || rec.head[2] != cfg.own_addr) begin
            verdict_c = VERDICT_OTHER;
        end else if (rec.head[1] == POLL_LENGTH && rec.head[3] == POLL_CODE) begin
            verdict_c = VERDICT_POLL;
        end else if (rec.head[1] == CMD_LENGTH && rec.head[3] == CMD_MARK) begin
            verdict_c = VERDICT_RADIO;
            code_c    = rec.head[4];
            param_c   = rec.head[5];
        end else begin
            verdict_c = VERDICT_UNKNOWN;
        end

        valid_next = valid_reg;
        if (pop) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            verdict_reg <= verdict_c;
            src_reg     <= rec.head[0];
            len_reg     <= rec.head[1];
            dst_reg     <= rec.head[2];
            code_reg    <= code_c;
            param_reg   <= param_c;
        end
    end

    assign m_valid         = valid_reg;
    assign m_verdict       = verdict_reg;
    assign m_frame_source  = src_reg;
    assign m_frame_dest    = dst_reg;
    assign m_frame_length  = len_reg;
    assign m_command_code  = code_reg;
    assign m_command_param = param_reg;

endmodule

// ===== hw/rtl/bus_frame_checker_classifier_unit.sv =====
// Top level of the bus frame checker and classifier.
//
//   channel   direction  handshake              payload
//   s_        in         s_valid / s_ready      rx_byte, rx_ok, frame_end
//   m_        out        m_valid / m_ready      verdict, source, dest, length, code, param
//   cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One byte item is taken every cycle while s_ready is high; m_valid rises once a frame's
// record has gone through the queue into the output register, when that register is free.
// The front accumulator sets the one-item-per-cycle figure; the two-entry record queue
// lets the front keep taking bytes while a verdict waits at the output.
// s_ready drops only when the queue is full; reset (aresetn low, synchronous) clears the
// front accumulator, queue pointers and m_valid and loads the default addresses. cfg_ready is always high.
`include "assert_macros.svh"

module bus_frame_checker_classifier_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    input  logic       s_rx_ok,
    input  logic       s_frame_end,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_verdict,
    output logic [7:0] m_frame_source,
    output logic [7:0] m_frame_dest,
    output logic [7:0] m_frame_length,
    output logic [7:0] m_command_code,
    output logic [7:0] m_command_param,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_index,
    input  logic [7:0] cfg_data
);
    import bfcc_pkg::*;

    cfg_t       cfg_reg, cfg_next;
    frame_rec_t front_rec, head_rec;
    q_status_t  q_stat;
    logic       push, pop;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_PARTNER_ADDR: cfg_next.partner_addr = cfg_data;
                CFG_OWN_ADDR:     cfg_next.own_addr     = cfg_data;
                default:          cfg_next              = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.partner_addr <= DEFAULT_PARTNER;
            cfg_reg.own_addr     <= DEFAULT_OWN;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    bfcc_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_rx_byte   (s_rx_byte),
        .s_rx_ok     (s_rx_ok),
        .s_frame_end (s_frame_end),
        .q_stat      (q_stat),
        .push        (push),
        .rec         (front_rec)
    );

    bfcc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_rec (front_rec),
        .pop      (pop),
        .head_rec (head_rec),
        .stat     (q_stat)
    );

    bfcc_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .rec             (head_rec),
        .q_stat          (q_stat),
        .pop             (pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_verdict       (m_verdict),
        .m_frame_source  (m_frame_source),
        .m_frame_dest    (m_frame_dest),
        .m_frame_length  (m_frame_length),
        .m_command_code  (m_command_code),
        .m_command_param (m_command_param)
    );

    // Command bytes are only reported for radio commands.
    `ASSERT_IMPLIES(a_cmd_zero, aclk, aresetn, m_valid && (m_verdict != VERDICT_RADIO), (m_command_code == 8'h00) && (m_command_param == 8'h00))
    // A full queue must hold off the byte stream.
    `ASSERT_IMPLIES(a_full_stalls, aclk, aresetn, q_stat.full, !s_ready)
    // A pushed record makes the queue non-empty on the next cycle.
    `ASSERT_NEXT(a_push_fills, aclk, aresetn, push, !q_stat.empty)

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the bus frame checker and classifier unit.
module tb_top;
    import bfcc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       ok;
        logic       last_byte;
    } rx_item_t;

    typedef struct packed {
        verdict_t   verdict;
        logic [7:0] source;
        logic [7:0] dest;
        logic [7:0] length;
        logic [7:0] code;
        logic [7:0] param;
    } frame_result_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_rx_byte = 8'h00;
    logic       s_rx_ok = 1'b0;
    logic       s_frame_end = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [2:0] m_verdict;
    logic [7:0] m_frame_source;
    logic [7:0] m_frame_dest;
    logic [7:0] m_frame_length;
    logic [7:0] m_command_code;
    logic [7:0] m_command_param;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_index = CFG_PARTNER_ADDR;
    logic [7:0] cfg_data = 8'h00;

    // Stimulus side.
    rx_item_t   bytes_to_send[$];
    logic [7:0] frame_bytes[$];
    int         stim_bytes = 0;
    int         send_gap = 0;
    logic       bursts_on = 1'b1;

    // Frame state and address copies used to predict each verdict.
    logic [7:0]    cfg_partner = DEFAULT_PARTNER;
    logic [7:0]    cfg_own = DEFAULT_OWN;
    logic [COUNT_W-1:0] rx_count = '0;
    logic [7:0]    rx_xor = 8'h00;
    logic          rx_err = 1'b0;
    logic [7:0]    rx_head[HEAD_DEPTH];
    frame_result_t verdicts_due[$];
    int            verdict_hits[8];

    // Result side.
    int   ready_gap = 0;
    logic long_stall_done = 1'b0;
    int   bytes_seen = 0;
    int   results_checked = 0;
    int   mismatches = 0;
    int   cycle_count = 0;

    bus_frame_checker_classifier_unit u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .s_rx_ok         (s_rx_ok),
        .s_frame_end     (s_frame_end),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_verdict       (m_verdict),
        .m_frame_source  (m_frame_source),
        .m_frame_dest    (m_frame_dest),
        .m_frame_length  (m_frame_length),
        .m_command_code  (m_command_code),
        .m_command_param (m_command_param),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #6 aclk = ~aclk;

    task automatic clear_rx_frame();
        rx_count = '0;
        rx_xor = 8'h00;
        rx_err = 1'b0;
        for (int i = 0; i < HEAD_DEPTH; i++) rx_head[i] = 8'h00;
    endtask

    // Fold one accepted item into the frame state; on the last byte, queue the verdict.
    task automatic classify_byte(input rx_item_t it);
        frame_result_t r;
        if (rx_count < HEAD_DEPTH) rx_head[rx_count] = it.rx_byte;
        if (rx_count < MAX_FRAME_BYTES) rx_count = rx_count + 1'b1;
        rx_xor = rx_xor ^ it.rx_byte;
        if (!it.ok) rx_err = 1'b1;
        if (it.last_byte) begin
            r.source = rx_head[0];
            r.length = rx_head[1];
            r.dest   = rx_head[2];
            r.code   = 8'h00;
            r.param  = 8'h00;
            if (rx_count < MIN_FRAME_BYTES) begin
                r.verdict = VERDICT_SHORT;
            end else if (rx_err) begin
                r.verdict = VERDICT_RXERR;
            end else if (rx_xor != 8'h00) begin
                r.verdict = VERDICT_BADXOR;
            end else if (r.length == 8'h00) begin
                r.verdict = VERDICT_ZEROLEN;
            end else if (r.source != cfg_partner || r.dest != cfg_own) begin
                r.verdict = VERDICT_OTHER;
            end else if (r.length == POLL_LENGTH && rx_head[3] == POLL_CODE) begin
                r.verdict = VERDICT_POLL;
            end else if (r.length == CMD_LENGTH && rx_head[3] == CMD_MARK) begin
                r.verdict = VERDICT_RADIO;
                r.code    = rx_head[4];
                r.param   = rx_head[5];
            end else begin
                r.verdict = VERDICT_UNKNOWN;
            end
            verdicts_due.push_back(r);
            verdict_hits[r.verdict]++;
            clear_rx_frame();
        end
    endtask

    task automatic check_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", field, want, got);
            mismatches++;
        end
    endtask

    task automatic put_head(input logic [7:0] src, input logic [7:0] len,
                            input logic [7:0] dst, input logic [7:0] mark);
        frame_bytes.push_back(src);
        frame_bytes.push_back(len);
        frame_bytes.push_back(dst);
        frame_bytes.push_back(mark);
    endtask

    // Queue the bytes in frame_bytes as one frame, optionally closed by an XOR checksum
    // (spoiled by sum_flip), with rx_ok low on byte err_pos (none if negative).
    task automatic send_frame(input logic with_sum, input logic [7:0] sum_flip,
                              input int err_pos);
        logic [7:0] sum;
        rx_item_t   it;
        sum = 8'h00;
        foreach (frame_bytes[i]) sum = sum ^ frame_bytes[i];
        if (with_sum) frame_bytes.push_back(sum ^ sum_flip);
        foreach (frame_bytes[i]) begin
            it.rx_byte   = frame_bytes[i];
            it.ok        = (i != err_pos);
            it.last_byte = (i == frame_bytes.size() - 1);
            bytes_to_send.push_back(it);
        end
        stim_bytes += frame_bytes.size();
        frame_bytes.delete();
    endtask

    // Well-formed polls and radio commands for half the frames, the rest broken on purpose.
    task automatic random_traffic(input int target);
        int         start_count;
        int         kind;
        int         shape;
        int         n;
        int         err;
        logic [7:0] src;
        logic [7:0] len;
        logic [7:0] dst;
        logic [7:0] mark;
        logic [7:0] flip;
        start_count = stim_bytes;
        while (stim_bytes - start_count < target) begin
            kind = $urandom_range(0, 99);
            if (kind >= 86) begin
                n = (kind < 93) ? $urandom_range(1, 4) : $urandom_range(1, 12);
                repeat (n) frame_bytes.push_back(8'($urandom));
                err = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n - 1) : -1;
                send_frame(kind >= 93 && $urandom_range(0, 1) == 1, 8'h00, err);
            end else begin
                shape = $urandom_range(0, 1);
                src   = cfg_partner;
                dst   = cfg_own;
                len   = shape ? CMD_LENGTH : POLL_LENGTH;
                mark  = shape ? CMD_MARK : POLL_CODE;
                flip  = 8'h00;
                err   = -1;
                if (kind >= 50 && kind < 58) begin
                    // Addressed to us, but the length and mark fit no known request.
                    if ($urandom_range(0, 1) == 1) begin
                        len = shape ? POLL_LENGTH : CMD_LENGTH;
                    end else begin
                        len  = 8'($urandom_range(1, 255));
                        mark = 8'($urandom);
                    end
                end else if (kind >= 58 && kind < 66) begin
                    if ($urandom_range(0, 2) != 1) src = 8'($urandom);
                    if ($urandom_range(0, 2) != 0) dst = 8'($urandom);
                end else if (kind >= 66 && kind < 72) begin
                    len = 8'h00;
                end else if (kind >= 72 && kind < 79) begin
                    flip = 8'($urandom_range(1, 255));
                end
                put_head(src, len, dst, mark);
                if (shape == 1) begin
                    frame_bytes.push_back(8'($urandom));
                    frame_bytes.push_back(8'($urandom));
                end
                repeat ($urandom_range(0, 3)) frame_bytes.push_back(8'($urandom));
                if (kind >= 79) err = $urandom_range(0, frame_bytes.size());
                send_frame(1'b1, flip, err);
            end
        end
    endtask

    task automatic wait_drained();
        while (bytes_to_send.size() != 0 || s_valid || verdicts_due.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic configure(input logic [7:0] partner, input logic [7:0] own);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_PARTNER_ADDR;
        cfg_data  <= partner;
        do @(posedge aclk); while (!cfg_ready);
        cfg_partner = partner;
        cfg_index <= CFG_OWN_ADDR;
        cfg_data  <= own;
        do @(posedge aclk); while (!cfg_ready);
        cfg_own = own;
        cfg_valid <= 1'b0;
    endtask

    always @(posedge aclk) begin : driver
        rx_item_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (bytes_to_send.size() != 0 && bursts_on &&
                         $urandom_range(0, 7) == 0) begin
                send_gap = $urandom_range(0, 7);
                s_valid <= 1'b0;
            end else if (bytes_to_send.size() != 0) begin
                nxt = bytes_to_send.pop_front();
                s_valid     <= 1'b1;
                s_rx_byte   <= nxt.rx_byte;
                s_rx_ok     <= nxt.ok;
                s_frame_end <= nxt.last_byte;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin : monitor
        rx_item_t      seen;
        frame_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                seen.rx_byte   = s_rx_byte;
                seen.ok        = s_rx_ok;
                seen.last_byte = s_frame_end;
                classify_byte(seen);
                bytes_seen++;
            end
            if (m_valid && m_ready) begin
                if (verdicts_due.size() == 0) begin
                    $error("result item with no frame waiting: verdict %0d", m_verdict);
                    mismatches++;
                end else begin
                    want = verdicts_due.pop_front();
                    check_field("verdict", 8'(want.verdict), 8'(m_verdict));
                    check_field("frame_source", want.source, m_frame_source);
                    check_field("frame_dest", want.dest, m_frame_dest);
                    check_field("frame_length", want.length, m_frame_length);
                    check_field("command_code", want.code, m_command_code);
                    check_field("command_param", want.param, m_command_param);
                end
                results_checked++;
            end
            if (!long_stall_done && bytes_seen >= 150) begin
                // Hold the output long enough for the record queue to fill and s_ready to drop.
                long_stall_done = 1'b1;
                ready_gap = 150;
            end
            if (ready_gap > 0) begin
                ready_gap--;
                m_ready <= 1'b0;
            end else if (bursts_on && $urandom_range(0, 7) == 0) begin
                ready_gap = $urandom_range(0, 7);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                 verdicts_due.size());
        $display("[bus_frame_checker_classifier_unit] ERROR");
        $finish;
    end

    initial begin
        clear_rx_frame();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // A one-byte frame with a receive error is still short, and missing head bytes read zero.
        frame_bytes.push_back(8'hFF);
        send_frame(1'b0, 8'h00, 0);
        frame_bytes.push_back(8'hFF);
        frame_bytes.push_back(8'h00);
        send_frame(1'b0, 8'h00, -1);
        put_head(cfg_partner, POLL_LENGTH, cfg_own, POLL_CODE);
        send_frame(1'b1, 8'h00, -1);
        put_head(cfg_partner, CMD_LENGTH, cfg_own, CMD_MARK);
        frame_bytes.push_back(8'hA5);
        frame_bytes.push_back(8'h5A);
        send_frame(1'b1, 8'h00, -1);
        put_head(cfg_partner, POLL_LENGTH, cfg_own, POLL_CODE);
        send_frame(1'b1, 8'h00, 2);
        random_traffic(80);
        wait_drained();

        configure(8'h00, 8'hFF);
        random_traffic(80);
        // One frame well past the byte count's saturation point.
        put_head(cfg_partner, CMD_LENGTH, cfg_own, CMD_MARK);
        repeat (266) frame_bytes.push_back(8'($urandom));
        send_frame(1'b1, 8'h00, -1);
        wait_drained();

        configure(8'hFF, 8'h00);
        random_traffic(80);
        wait_drained();

        configure(8'($urandom), 8'($urandom));
        bursts_on = 1'b0;
        random_traffic(80);
        wait_drained();

        $display("checked %0d results from %0d bytes under four address settings",
                 results_checked, bytes_seen);
        $display("verdicts: short %0d rxerr %0d badxor %0d zerolen %0d other %0d poll %0d %s",
                 verdict_hits[0], verdict_hits[1], verdict_hits[2], verdict_hits[3],
                 verdict_hits[4], verdict_hits[5],
                 $sformatf("radio %0d unknown %0d", verdict_hits[6], verdict_hits[7]));
        if (mismatches == 0) begin
            $display("[bus_frame_checker_classifier_unit] OK");
        end else begin
            $display("[bus_frame_checker_classifier_unit] ERROR");
        end
        $finish;
    end

endmodule

// ===== bus_frame_checker_classifier_unit.f =====
+incdir+hw/rtl
hw/rtl/bfcc_pkg.sv
hw/rtl/bfcc_front.sv
hw/rtl/bfcc_queue.sv
hw/rtl/bfcc_back.sv
hw/rtl/bus_frame_checker_classifier_unit.sv
sim/tb_top.sv
